/* design/ple_pkg.sv */
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 7;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_SEARCH    = 3'd6,
        CMD_NONE      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic reduce;
    } ple_ctrl_t;

    typedef struct packed {
        logic search;
    } ple_stat_t;

endpackage

/* design/ple_ctrl.sv */
// Controller state machine: sequences request capture, execution, search and response.
module ple_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ple_pkg::ple_stat_t stat,
    output ple_pkg::ple_ctrl_t ctrl
);
    import ple_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        ctrl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                ctrl.exec  = 1'b1;
                state_next = stat.search ? S_SRCH : S_DONE;
            end
            S_SRCH: begin
                ctrl.reduce = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* design/ple_dpath.sv */
// Datapath: shift-register cell chain, entry count, search compare and result registers.
module ple_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ple_pkg::ple_ctrl_t           ctrl,
    output ple_pkg::ple_stat_t           stat,
    input  ple_pkg::cmd_t                req_cmd,
    input  logic [ple_pkg::POS_W-1:0]    req_position,
    input  logic signed [ple_pkg::VAL_W-1:0] req_value,
    output ple_pkg::status_t             res_status,
    output logic                         res_found,
    output logic [ple_pkg::LEN_W-1:0]    res_length
);
    import ple_pkg::*;

    cmd_t                    cmd_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [VAL_W-1:0] cell_reg  [CAPACITY];
    logic signed [VAL_W-1:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0]     match_reg;
    logic [CAPACITY-1:0]     match_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic                    found_reg;
    logic                    do_ins;
    logic                    do_del;
    logic [IDX_W-1:0]        idx;
    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic [CMP_W-1:0]        pos_m1;
    logic [CMP_W-1:0]        cnt_m1;
    logic                    full;
    logic                    empty;

    assign stat.search = (cmd_reg == CMD_SEARCH);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg   <= req_cmd;
            pos_reg   <= req_position;
            value_reg <= req_value;
        end
    end

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign cnt_m1  = cnt_ext - CMP_W'(1);
    assign full    = (cnt_ext == CMP_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        idx         = '0;
        status_next = STAT_OK;
        unique case (cmd_reg)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else if (cmd_reg == CMD_INS_FRONT) begin
                    do_ins = 1'b1;
                end else if (cmd_reg == CMD_INS_END) begin
                    do_ins = 1'b1;
                    idx    = cnt_ext[IDX_W-1:0];
                end else if (pos_ext <= CMP_W'(1)) begin
                    do_ins = 1'b1;
                end else if (pos_ext <= cnt_ext + CMP_W'(1)) begin
                    do_ins = 1'b1;
                    idx    = pos_m1[IDX_W-1:0];
                end else begin
                    status_next = STAT_INVALID;
                end
            end
            CMD_DEL_FRONT, CMD_DEL_LAST, CMD_DEL_AT: begin
                if (empty) begin
                    status_next = STAT_EMPTY;
                end else if (cmd_reg == CMD_DEL_FRONT) begin
                    do_del = 1'b1;
                end else if (cmd_reg == CMD_DEL_LAST) begin
                    do_del = 1'b1;
                    idx    = cnt_m1[IDX_W-1:0];
                end else if (pos_ext >= CMP_W'(1) && pos_ext <= cnt_ext) begin
                    do_del = 1'b1;
                    idx    = pos_m1[IDX_W-1:0];
                end else begin
                    status_next = STAT_INVALID;
                end
            end
            CMD_SEARCH, CMD_NONE: begin
                status_next = STAT_OK;
            end
            default: status_next = STAT_OK;
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VAL_W-1:0] prev_val;
        logic signed [VAL_W-1:0] succ_val;

        if (i == 0) begin : g_first
            assign prev_val = req_value;
        end else begin : g_mid
            assign prev_val = cell_reg[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign succ_val = cell_reg[i];
        end else begin : g_inner
            assign succ_val = cell_reg[i+1];
        end

        always_comb begin
            cell_next[i] = cell_reg[i];
            if (ctrl.exec && do_ins) begin
                if (IDX_W'(i) == idx) begin
                    cell_next[i] = value_reg;
                end else if (IDX_W'(i) > idx) begin
                    cell_next[i] = prev_val;
                end
            end else if (ctrl.exec && do_del) begin
                if (IDX_W'(i) >= idx) begin
                    cell_next[i] = succ_val;
                end
            end
        end

        assign match_next[i] = (cell_reg[i] == value_reg) && (CNT_W'(i) < count_reg);

        always_ff @(posedge aclk) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.exec && do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.exec && do_del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            status_reg <= status_next;
            match_reg  <= match_next;
            found_reg  <= 1'b0;
        end else if (ctrl.reduce) begin
            found_reg <= |match_reg;
        end
    end

    assign res_status = status_reg;
    assign res_found  = found_reg;
    assign res_length = LEN_W'(count_reg);

endmodule

/* design/positional_list_engine.sv */
// Top level of the positional list engine: stream ports, controller and datapath.
//
//  channel | dir | fields in tdata (lowest bit up)           | width
//  s_      | in  | cmd[2:0], position[9:3], value[41:10]     | 48
//  m_      | out | status[1:0], found[2], length[9:3]        | 16
//
// A request runs in order: accept, execute on the cell chain and load the result
// registers, OR-reduce of the registered match vector for search, then result on m_.
// Result valid rises when the controller enters its done state, after the execute
// state and, for search, the search state. Insert and delete shift all cells at once.
// Reset clears the entry count; cell contents stay undefined until written.
// The next request is taken only once the result has been taken on m_.
module positional_list_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ple_pkg::S_DATA_W-1:0]  s_tdata,  // cmd, position, value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ple_pkg::M_DATA_W-1:0]  m_tdata   // status, found, length
);
    import ple_pkg::*;

    ple_ctrl_t               ctrl;
    ple_stat_t               stat;
    cmd_t                    req_cmd;
    logic [POS_W-1:0]        req_position;
    logic signed [VAL_W-1:0] req_value;
    status_t                 res_status;
    logic                    res_found;
    logic [LEN_W-1:0]        res_length;

    assign req_cmd      = cmd_t'(s_tdata[2:0]);
    assign req_position = s_tdata[3 +: POS_W];
    assign req_value    = s_tdata[3 + POS_W +: VAL_W];

    ple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ple_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .stat         (stat),
        .req_cmd      (req_cmd),
        .req_position (req_position),
        .req_value    (req_value),
        .res_status   (res_status),
        .res_found    (res_found),
        .res_length   (res_length)
    );

    assign m_tdata = {{(M_DATA_W - 3 - LEN_W){1'b0}}, res_length, res_found, res_status};

endmodule

/* design/ple_checker.sv */
// Port-level checker for the positional list engine, bound to the top level.
module ple_port_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ple_pkg::M_DATA_W-1:0] m_tdata
);
    import ple_pkg::*;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    logic [1:0]       st;
    logic [LEN_W-1:0] len;

    assign st  = m_tdata[1:0];
    assign len = m_tdata[9:3];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while a result is pending");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("engine not busy after request");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == STAT_FULL |-> len == CAP_LEN && !m_tdata[2])
        else $error("full status with wrong length");

    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == STAT_EMPTY |-> len == '0 && !m_tdata[2])
        else $error("empty status with nonzero length");

endmodule

bind positional_list_engine ple_port_checker u_ple_checker (.*);

/* sim/ple_checker.sv */
// Checker for the positional list engine: tracks the list, predicts each result and compares.
module ple_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ple_pkg::S_DATA_W-1:0]  s_tdata,  // cmd, position, value
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ple_pkg::M_DATA_W-1:0]  m_tdata,  // status, found, length
    output int                            fail_count,
    output int                            pending,
    output int                            list_len
);

    import ple_pkg::*;

    typedef struct {
        status_t          status;
        logic             found;
        logic [LEN_W-1:0] length;
    } list_result_t;

    logic [VAL_W-1:0] stored_values[$];
    list_result_t     awaited_results[$];
    int               failures = 0;
    int               results_seen = 0;

    function automatic list_result_t apply_request(cmd_t op, logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] val);
        list_result_t r;
        int           n;
        int           p;
        n = stored_values.size();
        p = pos;
        r.status = STAT_OK;
        r.found  = 1'b0;
        case (op)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
                if (n >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else if (op == CMD_INS_FRONT || (op == CMD_INS_AT && p <= 1)) begin
                    stored_values.push_front(val);
                end else if (op == CMD_INS_END) begin
                    stored_values.push_back(val);
                end else if (p <= n + 1) begin
                    stored_values.insert(p - 1, val);
                end else begin
                    r.status = STAT_INVALID;
                end
            end
            CMD_DEL_FRONT, CMD_DEL_LAST, CMD_DEL_AT: begin
                if (n == 0) begin
                    r.status = STAT_EMPTY;
                end else if (op == CMD_DEL_FRONT) begin
                    void'(stored_values.pop_front());
                end else if (op == CMD_DEL_LAST) begin
                    void'(stored_values.pop_back());
                end else if (p >= 1 && p <= n) begin
                    stored_values.delete(p - 1);
                end else begin
                    r.status = STAT_INVALID;
                end
            end
            CMD_SEARCH: begin
                foreach (stored_values[i]) begin
                    if (stored_values[i] == val) begin
                        r.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.length = LEN_W'(stored_values.size());
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            stored_values.delete();
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[1:0]);
                got.found  = m_tdata[2];
                got.length = m_tdata[9:3];
                results_seen++;
                if (awaited_results.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("unexpected result %0d: status %0d found %0d length %0d",
                                 results_seen, got.status, got.found, got.length);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.length !== want.length) begin
                        failures++;
                        if (failures <= 10) begin
                            $display({"mismatch on result %0d (expected/actual): ",
                                      "status %0d/%0d found %0d/%0d length %0d/%0d"},
                                     results_seen, want.status, got.status,
                                     want.found, got.found, want.length, got.length);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_request(cmd_t'(s_tdata[2:0]),
                                                        s_tdata[9:3], s_tdata[41:10]));
            end
        end
        fail_count <= failures;
        pending    <= awaited_results.size();
        list_len   <= stored_values.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the positional list engine: clock, reset, request stimulus and verdict.
module tb_top;

    import ple_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 103;

    typedef enum {GROW, SHRINK, MIX} drift_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int list_len;
    int stalled = 0;
    bit calm;

    drift_t plan [PHASES] = '{GROW, MIX, SHRINK, GROW, GROW, SHRINK, MIX, GROW, SHRINK,
                              MIX, GROW};
    logic [VAL_W-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                         32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005,
                                         32'hDEAD_BEEF, 32'h0000_1234};

    always #5 aclk = ~aclk;

    positional_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ple_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .list_len   (list_len)
    );

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        return value_pool[$urandom_range(7)];
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int len);
        case ($urandom_range(9))
            0: return POS_W'($urandom_range(127));
            1: return '0;
            2: return POS_W'(len + 1);
            3: return POS_W'(len + 2);
            default: return POS_W'($urandom_range(len + 1, 1));
        endcase
    endfunction

    function automatic cmd_t pick_insert();
        case ($urandom_range(3))
            0: return CMD_INS_FRONT;
            1: return CMD_INS_END;
            default: return CMD_INS_AT;
        endcase
    endfunction

    function automatic cmd_t pick_delete();
        case ($urandom_range(3))
            0: return CMD_DEL_FRONT;
            1: return CMD_DEL_LAST;
            default: return CMD_DEL_AT;
        endcase
    endfunction

    function automatic cmd_t pick_cmd(drift_t drift);
        int roll;
        int ins_cut;
        int del_cut;
        roll = $urandom_range(99);
        case (drift)
            GROW:    begin ins_cut = 85; del_cut = 95; end
            SHRINK:  begin ins_cut = 7;  del_cut = 92; end
            default: begin ins_cut = 40; del_cut = 75; end
        endcase
        if (roll < ins_cut) return pick_insert();
        if (roll < del_cut) return pick_delete();
        if (roll < 99) return CMD_SEARCH;
        return CMD_NONE;
    endfunction

    task automatic send_req(input cmd_t op, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        if (!calm && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, val, pos, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin : ready_gen
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (calm || $urandom_range(2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(16, 1)) @(negedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stalled <= 0;
            end else begin
                stalled <= stalled + 1;
            end
            if (stalled >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int          ph;
        int          k;
        cmd_t        op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        calm     = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list, bad positions, every command, extreme values
        send_req(CMD_SEARCH,    7'd0,   32'h0000_0000);
        send_req(CMD_DEL_FRONT, 7'd0,   32'h0000_0000);
        send_req(CMD_DEL_LAST,  7'd0,   32'h0000_0000);
        send_req(CMD_DEL_AT,    7'd0,   32'h0000_0000);
        send_req(CMD_INS_AT,    7'd127, 32'h1234_5678);
        send_req(CMD_INS_AT,    7'd0,   32'h8000_0000);
        send_req(CMD_INS_AT,    7'd1,   32'h7FFF_FFFF);
        send_req(CMD_INS_FRONT, 7'd0,   32'hFFFF_FFFF);
        send_req(CMD_INS_END,   7'd0,   32'h0000_0000);
        send_req(CMD_INS_AT,    7'd5,   32'h5555_5555);
        send_req(CMD_INS_AT,    7'd3,   32'hAAAA_AAAA);
        send_req(CMD_INS_AT,    7'd8,   32'h0000_0001);
        send_req(CMD_SEARCH,    7'd0,   32'h8000_0000);
        send_req(CMD_SEARCH,    7'd0,   32'h1234_5678);
        send_req(CMD_DEL_AT,    7'd0,   32'h0000_0000);
        send_req(CMD_DEL_AT,    7'd7,   32'h0000_0000);
        send_req(CMD_DEL_AT,    7'd127, 32'h0000_0000);
        send_req(CMD_DEL_AT,    7'd6,   32'h0000_0000);
        send_req(CMD_DEL_AT,    7'd1,   32'h0000_0000);
        send_req(CMD_DEL_AT,    7'd2,   32'h0000_0000);
        send_req(CMD_NONE,      7'd127, 32'hFFFF_FFFF);
        send_req(CMD_DEL_FRONT, 7'd0,   32'h0000_0000);
        send_req(CMD_DEL_LAST,  7'd0,   32'h0000_0000);
        send_req(CMD_DEL_LAST,  7'd0,   32'h0000_0000);

        // drift the list between empty and full, last phase without idling
        for (ph = 0; ph < PHASES; ph++) begin
            calm = (ph == PHASES - 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                op  = pick_cmd(plan[ph]);
                pos = pick_position(list_len);
                val = pick_value();
                send_req(op, pos, val);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
